@@ rtl/rmq_pkg.sv @@
package rmq_pkg;

	// element and result word width, signed fixed point
	localparam int ELEM_W = 16;
	// width of a skew difference or sum of two elements
	localparam int NUM_W = 17;
	// quotient bits below the saturation point
	localparam int Q_BITS = 15;

	localparam logic signed [ELEM_W-1:0] SAT_MAX = 16'sh7FFF;
	localparam logic signed [ELEM_W-1:0] SAT_MIN = -16'sh8000;

	// component that takes the halved root
	typedef enum logic [1:0] {
		LEAD_X,
		LEAD_Y,
		LEAD_Z,
		LEAD_S
	} lead_t;

endpackage

@@ rtl/rotation_matrix_to_quaternion.sv @@
// channel  dir  tdata bits                    meaning
// s_*      in   144: r0c0 r0c1 ... r2c2        3x3 rotation matrix, signed fixed point
// m_*      out  64:  quat_x quat_y quat_z quat_w quaternion, signed fixed point
//
// One word in per cycle unless the output stalls; one word out per word in, in order.
// Registers in order: input, the bit-per-stage root pipeline of SW stages (SW is the
// root width), halving, the 16 divider stages, output.
// Reset clears every valid bit; no clearing pass.
// A stalled output freezes the whole pipeline; bubbles are carried, nothing is dropped.
module rotation_matrix_to_quaternion
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [143:0] s_tdata,   // r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0 r2c1 r2c2
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata    // quat_x quat_y quat_z quat_w
);

	localparam int AU  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
	localparam int AS  = AU + 1;
	localparam int VW  = AU + FRAC_BITS;
	localparam int SW  = (VW + 1) / 2;
	localparam int SB1 = 2 + 3 * NUM_W;
	localparam int SB2 = 2 + 1 + ELEM_W;
	localparam logic signed [AS-1:0] ONE = AS'(64'sd1 <<< FRAC_BITS);

	logic en;
	logic m_tvalid_q;
	logic [63:0] m_tdata_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	// stage 0: branch, radicand and numerators
	logic signed [ELEM_W-1:0] m [3][3];
	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			assign m[r][c] = signed'(s_tdata[(r*3+c)*ELEM_W +: ELEM_W]);
		end
	end

	logic signed [AS-1:0]    trace;
	logic signed [AS-1:0]    arg_c;
	logic signed [NUM_W-1:0] na_c, nb_c, nc_c;
	lead_t                   lead_c;

	always_comb begin
		trace = AS'(m[0][0]) + AS'(m[1][1]) + AS'(m[2][2]);
		if (trace > 0) begin
			lead_c = LEAD_S;
			arg_c  = trace + ONE;
			na_c   = NUM_W'(m[2][1]) - NUM_W'(m[1][2]);
			nb_c   = NUM_W'(m[0][2]) - NUM_W'(m[2][0]);
			nc_c   = NUM_W'(m[1][0]) - NUM_W'(m[0][1]);
		end else if (m[2][2] > m[0][0] && m[2][2] > m[1][1]) begin
			lead_c = LEAD_Z;
			arg_c  = AS'(m[2][2]) - (AS'(m[0][0]) + AS'(m[1][1])) + ONE;
			na_c   = NUM_W'(m[1][0]) - NUM_W'(m[0][1]);
			nb_c   = NUM_W'(m[0][2]) + NUM_W'(m[2][0]);
			nc_c   = NUM_W'(m[1][2]) + NUM_W'(m[2][1]);
		end else if (m[1][1] > m[0][0]) begin
			lead_c = LEAD_Y;
			arg_c  = AS'(m[1][1]) - (AS'(m[2][2]) + AS'(m[0][0])) + ONE;
			na_c   = NUM_W'(m[0][2]) - NUM_W'(m[2][0]);
			nb_c   = NUM_W'(m[2][1]) + NUM_W'(m[1][2]);
			nc_c   = NUM_W'(m[0][1]) + NUM_W'(m[1][0]);
		end else begin
			lead_c = LEAD_X;
			arg_c  = AS'(m[0][0]) - (AS'(m[1][1]) + AS'(m[2][2])) + ONE;
			na_c   = NUM_W'(m[2][1]) - NUM_W'(m[1][2]);
			nb_c   = NUM_W'(m[1][0]) + NUM_W'(m[0][1]);
			nc_c   = NUM_W'(m[2][0]) + NUM_W'(m[0][2]);
		end
		// a radicand at or below zero gives a zero root
		if (arg_c <= 0) begin
			arg_c = '0;
		end
	end

	logic                    vld_s1;
	logic [AU-1:0]           arg_s1;
	lead_t                   lead_s1;
	logic signed [NUM_W-1:0] na_s1, nb_s1, nc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			arg_s1  <= arg_c[AU-1:0];
			lead_s1 <= lead_c;
			na_s1   <= na_c;
			nb_s1   <= nb_c;
			nc_s1   <= nc_c;
		end
	end

	// root pipeline
	logic           sq_vld;
	logic [SW-1:0]  sq_root;
	logic [SB1-1:0] sq_sb;

	rmq_sqrt #(
		.VW (VW),
		.SBW(SB1)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s1),
		.radicand (VW'(arg_s1) << FRAC_BITS),
		.in_sb    ({lead_s1, na_s1, nb_s1, nc_s1}),
		.out_valid(sq_vld),
		.root     (sq_root),
		.out_sb   (sq_sb)
	);

	// halved root, rounded up and saturated
	logic [SW:0]              half_c;
	logic                     vld_s2;
	logic                     zero_s2;
	logic [ELEM_W-1:0]        half_s2;
	logic [SW-1:0]            root_s2;
	lead_t                    lead_s2;
	logic signed [NUM_W-1:0]  n_s2 [3];

	assign half_c = ((SW + 1)'(sq_root) + 1'b1) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s2 <= sq_root == '0;
			half_s2 <= (half_c > (SW + 1)'(SAT_MAX)) ? SAT_MAX : ELEM_W'(half_c);
			root_s2 <= sq_root;
			lead_s2 <= lead_t'(sq_sb[SB1-1 -: 2]);
			n_s2[0] <= signed'(sq_sb[3*NUM_W-1 -: NUM_W]);
			n_s2[1] <= signed'(sq_sb[2*NUM_W-1 -: NUM_W]);
			n_s2[2] <= signed'(sq_sb[NUM_W-1:0]);
		end
	end

	// three dividers in lockstep
	logic                     dv_vld;
	logic signed [ELEM_W-1:0] dv_q [3];
	logic [SB2-1:0]           dv_sb;

	rmq_div #(
		.FRAC_BITS(FRAC_BITS),
		.SW       (SW),
		.SBW      (SB2)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s2),
		.s        (root_s2),
		.n        (n_s2),
		.in_sb    ({lead_s2, zero_s2, half_s2}),
		.out_valid(dv_vld),
		.q        (dv_q),
		.out_sb   (dv_sb)
	);

	// route terms to components
	lead_t             lead_o;
	logic              zero_o;
	logic [ELEM_W-1:0] half_o;
	logic [ELEM_W-1:0] qx, qy, qz, qw;

	assign lead_o = lead_t'(dv_sb[SB2-1 -: 2]);
	assign zero_o = dv_sb[ELEM_W];
	assign half_o = dv_sb[ELEM_W-1:0];

	always_comb begin
		case (lead_o)
			LEAD_X: begin
				qx = half_o; qw = dv_q[0]; qy = dv_q[1]; qz = dv_q[2];
			end
			LEAD_Y: begin
				qy = half_o; qw = dv_q[0]; qz = dv_q[1]; qx = dv_q[2];
			end
			LEAD_Z: begin
				qz = half_o; qw = dv_q[0]; qx = dv_q[1]; qy = dv_q[2];
			end
			default: begin
				qw = half_o; qx = dv_q[0]; qy = dv_q[1]; qz = dv_q[2];
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= zero_o ? '0 : {qw, qz, qy, qx};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// positive trace always gives a radicand above one
	a_trace_arg: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && lead_s1 == LEAD_S) |-> (arg_s1 > AU'(ONE)))
		else $error("trace branch radicand not above one");

	// a nonzero root never halves to zero
	a_half_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && !zero_s2) |-> (half_s2 != '0))
		else $error("halved root zero for nonzero root");

	// a stall freezes the pipeline
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(vld_s1) && $stable(vld_s2)))
		else $error("pipeline moved during stall");

endmodule

@@ rtl/rmq_sqrt.sv @@
module rmq_sqrt #(
	parameter int VW = 32,
	parameter int SBW = 1,
	localparam int SW = (VW + 1) / 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [VW-1:0]  radicand,
	input  logic [SBW-1:0] in_sb,
	output logic           out_valid,
	output logic [SW-1:0]  root,
	output logic [SBW-1:0] out_sb
);

	localparam int RW = 2 * SW + 1;

	logic           vld_s  [SW];
	logic [SW-1:0]  root_s [SW];
	logic [SBW-1:0] sb_s   [SW];
	logic [RW-1:0]  rem_s  [SW-1];

	// one root bit per stage, most significant first
	for (genvar k = 0; k < SW; k++) begin : g_stage
		localparam int B = SW - 1 - k;
		logic [RW-1:0]  rem_in;
		logic [RW-1:0]  trial;
		logic [SW-1:0]  root_in;
		logic           vld_in;
		logic [SBW-1:0] sb_in;
		logic           take;

		if (k == 0) begin : g_first
			assign rem_in  = RW'(radicand);
			assign root_in = '0;
			assign vld_in  = in_valid;
			assign sb_in   = in_sb;
		end else begin : g_next
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign vld_in  = vld_s[k-1];
			assign sb_in   = sb_s[k-1];
		end

		// (r + 2^B)^2 - r^2
		assign trial = (RW'(root_in) << (B + 1)) + (RW'(1) << (2 * B));
		assign take  = rem_in >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k] <= take ? (root_in | (SW'(1) << B)) : root_in;
				sb_s[k]   <= sb_in;
			end
		end

		if (k < SW - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take ? (rem_in - trial) : rem_in;
				end
			end
		end
	end

	assign out_valid = vld_s[SW-1];
	assign root      = root_s[SW-1];
	assign out_sb    = sb_s[SW-1];

endmodule

@@ rtl/rmq_div.sv @@
module rmq_div
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = 14,
	parameter int SW = 16,
	parameter int SBW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [SW-1:0]            s,
	input  logic signed [NUM_W-1:0]  n [3],
	input  logic [SBW-1:0]           in_sb,
	output logic                     out_valid,
	output logic signed [ELEM_W-1:0] q [3],
	output logic [SBW-1:0]           out_sb
);

	localparam int NW = FRAC_BITS + NUM_W + 1;
	localparam int CW = (NW > SW + Q_BITS + 1) ? NW : SW + Q_BITS + 1;

	logic              vld_s [Q_BITS+1];
	logic [SBW-1:0]    sb_s  [Q_BITS+1];
	logic              ovf_s [Q_BITS+1][3];
	logic              neg_s [Q_BITS+1][3];
	logic [CW-1:0]     den_s [Q_BITS];
	logic [CW-1:0]     rem_s [Q_BITS][3];
	logic [Q_BITS-1:0] q_s   [Q_BITS][3];

	logic [CW-1:0] den_in;
	assign den_in = CW'(s) << 1;

	// entry: magnitude, rounding offset, overflow check
	for (genvar l = 0; l < 3; l++) begin : g_entry
		logic              neg;
		logic [NUM_W-1:0]  mag;
		logic [CW-1:0]     numer;

		assign neg   = n[l] < 0;
		assign mag   = neg ? NUM_W'(-n[l]) : NUM_W'(n[l]);
		assign numer = (CW'(mag) << FRAC_BITS) + CW'(s);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= numer;
				neg_s[0][l] <= neg;
				ovf_s[0][l] <= numer >= (den_in << Q_BITS);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den_in;
			sb_s[0]  <= in_sb;
		end
	end

	// restoring division, one quotient bit per stage
	for (genvar t = 1; t <= Q_BITS; t++) begin : g_stage
		localparam int B = Q_BITS - t;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[t] <= 1'b0;
			end else if (en) begin
				vld_s[t] <= vld_s[t-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[t] <= sb_s[t-1];
			end
		end

		if (t < Q_BITS) begin : g_den
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[t] <= den_s[t-1];
				end
			end
		end

		for (genvar l = 0; l < 3; l++) begin : g_lane
			logic [CW-1:0]     trial;
			logic [Q_BITS-1:0] q_in;
			logic              take;

			if (t == 1) begin : g_first
				assign q_in = '0;
			end else begin : g_next
				assign q_in = q_s[t-2][l];
			end

			assign trial = den_s[t-1] << B;
			assign take  = rem_s[t-1][l] >= trial;

			always_ff @(posedge clk) begin
				if (en) begin
					q_s[t-1][l]   <= take ? (q_in | (Q_BITS'(1) << B)) : q_in;
					ovf_s[t][l]   <= ovf_s[t-1][l];
					neg_s[t][l]   <= neg_s[t-1][l];
				end
			end

			if (t < Q_BITS) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						rem_s[t][l] <= take ? (rem_s[t-1][l] - trial) : rem_s[t-1][l];
					end
				end
			end
		end
	end

	// sign and saturation
	for (genvar l = 0; l < 3; l++) begin : g_out
		logic signed [ELEM_W-1:0] mag_q;
		assign mag_q = signed'(ELEM_W'(q_s[Q_BITS-1][l]));
		always_comb begin
			if (ovf_s[Q_BITS][l]) begin
				q[l] = neg_s[Q_BITS][l] ? SAT_MIN : SAT_MAX;
			end else begin
				q[l] = neg_s[Q_BITS][l] ? -mag_q : mag_q;
			end
		end
	end

	assign out_valid = vld_s[Q_BITS];
	assign out_sb    = sb_s[Q_BITS];

endmodule

@@ tb/rotation_matrix_to_quaternion_tb.sv @@
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
	import rmq_pkg::*;

	localparam int FRAC = 14;
	localparam int PIPE_LAT = 40;
	localparam int WDOG_LIMIT = 3000;

	typedef struct {
		logic signed [ELEM_W-1:0] x;
		logic signed [ELEM_W-1:0] y;
		logic signed [ELEM_W-1:0] z;
		logic signed [ELEM_W-1:0] w;
	} quat_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [143:0] s_tdata;   // r0c0 r0c1 r0c2 r1c0 r1c1 r1c2 r2c0 r2c1 r2c2
	logic         m_tvalid;
	logic         m_tready;
	logic [63:0]  m_tdata;   // quat_x quat_y quat_z quat_w

	quat_t quat_due[$];
	int    errors = 0;
	int    src_idle_pct = 0;
	int    snk_stall_pct = 0;
	int    snk_hold = 0;
	int    quiet_cycles = 0;

	rotation_matrix_to_quaternion #(.FRAC_BITS(FRAC)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// integer square root, bit by bit
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic logic signed [15:0] clamp16(input longint v);
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return v[15:0];
	endfunction

	function automatic longint unsigned root_of(input longint arg);
		if (arg <= 0) return 0;
		return int_sqrt(longint'(arg) << FRAC);
	endfunction

	// n / (2s), rounded half away from zero
	function automatic longint div_by_root(input longint n, input longint unsigned s);
		longint unsigned mag;
		longint unsigned den;
		longint unsigned q;
		mag = (n < 0) ? -n : n;
		den = s * 2;
		mag <<= FRAC;
		q = (mag + den / 2) / den;
		if (q > (64'd1 << 40)) q = 64'd1 << 40;
		return (n < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic quat_t matrix_to_quat(input logic [143:0] d);
		longint m[3][3];
		longint q[3];
		longint w;
		longint tr;
		longint unsigned s;
		int i, j, k;
		quat_t r;
		for (int a = 0; a < 3; a++)
			for (int b = 0; b < 3; b++)
				m[a][b] = longint'($signed(d[16*(a*3+b) +: 16]));
		q[0] = 0; q[1] = 0; q[2] = 0; w = 0;
		tr = m[0][0] + m[1][1] + m[2][2];
		if (tr > 0) begin
			s = root_of(tr + (64'sd1 << FRAC));
			if (s != 0) begin
				w = longint'((s + 1) >> 1);
				q[0] = div_by_root(m[2][1] - m[1][2], s);
				q[1] = div_by_root(m[0][2] - m[2][0], s);
				q[2] = div_by_root(m[1][0] - m[0][1], s);
			end
		end else begin
			i = 0;
			if (m[1][1] > m[0][0]) i = 1;
			if (m[2][2] > m[i][i]) i = 2;
			j = (i + 1) % 3;
			k = (j + 1) % 3;
			s = root_of(m[i][i] - (m[j][j] + m[k][k]) + (64'sd1 << FRAC));
			if (s != 0) begin
				q[i] = longint'((s + 1) >> 1);
				w = div_by_root(m[k][j] - m[j][k], s);
				q[j] = div_by_root(m[j][i] + m[i][j], s);
				q[k] = div_by_root(m[k][i] + m[i][k], s);
			end
		end
		r.x = clamp16(q[0]);
		r.y = clamp16(q[1]);
		r.z = clamp16(q[2]);
		r.w = clamp16(w);
		return r;
	endfunction

	function automatic logic [143:0] pack_matrix(input logic [15:0] e[9]);
		logic [143:0] d;
		for (int n = 0; n < 9; n++) d[16*n +: 16] = e[n];
		return d;
	endfunction

	// offer one word, with random idle cycles in front
	task automatic send_matrix(input logic [143:0] d);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		quat_due.push_back(matrix_to_quat(d));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (quat_due.size() != 0) @(posedge clk);
		repeat (PIPE_LAT) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_elem();
		int sel;
		sel = $urandom_range(9);
		case (sel)
			0: begin
				return 16'h7FFF;
			end
			1: begin
				return 16'h8000;
			end
			2: begin
				return 16'h4000;
			end
			3: begin
				return 16'hC000;
			end
			4, 5, 6: begin
				return 16'($signed($urandom_range(32768)) - 16384);
			end
			default: begin
				return 16'($urandom);
			end
		endcase
	endfunction

	// random matrix; on about half the calls the diagonal is biased to one axis
	function automatic logic [143:0] rand_matrix();
		logic [15:0] e[9];
		int lead;
		for (int n = 0; n < 9; n++) e[n] = rand_elem();
		if ($urandom_range(1)) begin
			lead = $urandom_range(2);
			for (int n = 0; n < 3; n++)
				e[n*4] = (n == lead) ? 16'($urandom_range(16384, 8000))
				                     : 16'(-$signed($urandom_range(16384)));
		end
		return pack_matrix(e);
	endfunction

	task automatic test_directed();
		logic [15:0] e[9];
		// identity, zero matrix
		e = '{16'h4000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'h4000};
		send_matrix(pack_matrix(e));
		e = '{default: 16'h0};
		send_matrix(pack_matrix(e));
		// half turns about each axis: each leading component
		e = '{16'h4000, 0, 0, 0, 16'hC000, 0, 0, 0, 16'hC000};
		send_matrix(pack_matrix(e));
		e = '{16'hC000, 0, 0, 0, 16'h4000, 0, 0, 0, 16'hC000};
		send_matrix(pack_matrix(e));
		e = '{16'hC000, 0, 0, 0, 16'hC000, 0, 0, 0, 16'h4000};
		send_matrix(pack_matrix(e));
		// ties on the diagonal
		e = '{16'hC000, 16'h1000, 0, 0, 16'hC000, 16'h2000, 0, 0, 16'hD000};
		send_matrix(pack_matrix(e));
		e = '{default: 16'h8000};
		send_matrix(pack_matrix(e));
		e = '{default: 16'h7FFF};
		send_matrix(pack_matrix(e));
		e = '{default: 16'hFFFF};
		send_matrix(pack_matrix(e));
		// large skew terms saturate
		e = '{16'h0001, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h8000,
		      16'h8000, 16'h7FFF, 16'h0000};
		send_matrix(pack_matrix(e));
		e = '{16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF,
		      16'h7FFF, 16'h7FFF, 16'h8000};
		send_matrix(pack_matrix(e));
		e = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000,
		      16'h8000, 16'h8000, 16'h8000};
		send_matrix(pack_matrix(e));
		// 90 degrees about z
		e = '{0, 16'hC000, 0, 16'h4000, 0, 0, 0, 0, 16'h4000};
		send_matrix(pack_matrix(e));
		wait_drained();
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		src_idle_pct  = idle_pct;
		snk_stall_pct = stall_pct;
		for (int c = 0; c < n; c++) send_matrix(rand_matrix());
		wait_drained();
		src_idle_pct  = 0;
		snk_stall_pct = 0;
	endtask

	// output held off while input keeps offering, then sender waits for drain
	task automatic test_backpressure();
		snk_hold = 300;
		for (int c = 0; c < 80; c++) send_matrix(rand_matrix());
		wait_drained();
		for (int c = 0; c < 20; c++) send_matrix(rand_matrix());
		wait_drained();
	endtask

	// output ready
	always @(posedge clk) begin
		if (snk_hold > 0) begin
			snk_hold <= snk_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	function automatic void check_field(input string name, input logic [15:0] exp_v,
	                                    input logic [15:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0d, got %0d", name, $signed(exp_v), $signed(act_v));
			errors++;
		end
	endfunction

	// compare each output word with the oldest prediction
	always @(posedge clk) begin
		quat_t q;
		if (arst_n && m_tvalid && m_tready) begin
			if (quat_due.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				errors++;
			end else begin
				q = quat_due.pop_front();
				check_field("quat_x", q.x, m_tdata[15:0]);
				check_field("quat_y", q.y, m_tdata[31:16]);
				check_field("quat_z", q.z, m_tdata[47:32]);
				check_field("quat_w", q.w, m_tdata[63:48]);
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles > WDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(200, 0, 0);
		test_random(150, 68, 0);
		test_random(150, 0, 68);
		test_random(150, 28, 28);
		test_backpressure();
		if (quat_due.size() != 0) begin
			$error("%0d predictions never matched", quat_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
